// ===== design/decimal_long_division_defines.svh =====
// Assertion macros for the file that checks this block.
`ifndef DECIMAL_LONG_DIVISION_DEFINES_SVH
`define DECIMAL_LONG_DIVISION_DEFINES_SVH

// Condition and consequence in the same cycle.
`define DLD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define DLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dld_pkg.sv =====
package dld_pkg;

  localparam int DEFAULT_MAX_FRACTION_DIGITS = 32;
  localparam int DEFAULT_MAGNITUDE_BITS      = 32;

  // 10^9 needs 30 bits, so a scaled operand needs MAGNITUDE_BITS + 30
  localparam int SCALE_BITS = 30;

  localparam logic [3:0] MAX_SCALE = 4'd9;

  localparam logic [5:0] FRACTION_DIGITS_RESET = 6'd6;

  localparam int APB_ADDR_BITS = 3;
  localparam logic REG_FRACTION_DIGITS = 1'b0;

  // Symbol kinds
  localparam logic [1:0] KIND_DIGIT    = 2'd0;
  localparam logic [1:0] KIND_POINT    = 2'd1;
  localparam logic [1:0] KIND_MINUS    = 2'd2;
  localparam logic [1:0] KIND_DIV_ZERO = 2'd3;

  // Emit selections from the controller
  localparam logic [2:0] EMIT_ERR   = 3'd0;
  localparam logic [2:0] EMIT_MINUS = 3'd1;
  localparam logic [2:0] EMIT_INT   = 3'd2;
  localparam logic [2:0] EMIT_POINT = 3'd3;
  localparam logic [2:0] EMIT_FRAC  = 3'd4;

  typedef struct packed {
    logic       load;
    logic       scale;
    logic       div_step;
    logic       skip;
    logic       frac_mul;
    logic       frac_step;
    logic       emit;
    logic [2:0] emit_sel;
  } dld_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic scale_done;
    logic div_last;
    logic show_minus;
    logic lead_zero;
    logic dcnt_one;
    logic frac_more;
    logic fstep_last;
    logic frac_last;
    logic out_free;
  } dld_status_t;

  function automatic logic [3:0] clamp_scale(input logic [3:0] s);
    return (s > MAX_SCALE) ? MAX_SCALE : s;
  endfunction

endpackage

// ===== design/dld_in_if.sv =====
interface dld_in_if;
  logic        valid;
  logic        ready;
  logic        numerator_negative;
  logic [31:0] numerator_magnitude;
  logic [3:0]  numerator_scale;
  logic        denominator_negative;
  logic [31:0] denominator_magnitude;
  logic [3:0]  denominator_scale;

  modport source (
    output valid, numerator_negative, numerator_magnitude, numerator_scale,
           denominator_negative, denominator_magnitude, denominator_scale,
    input  ready
  );

  modport sink (
    input  valid, numerator_negative, numerator_magnitude, numerator_scale,
           denominator_negative, denominator_magnitude, denominator_scale,
    output ready
  );
endinterface

// ===== design/dld_out_if.sv =====
interface dld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol_kind;
  logic [3:0] digit_value;
  logic       last_symbol;

  modport source (
    output valid, symbol_kind, digit_value, last_symbol,
    input  ready
  );

  modport sink (
    input  valid, symbol_kind, digit_value, last_symbol,
    output ready
  );
endinterface

// ===== design/dld_datapath.sv =====
module dld_datapath
  import dld_pkg::*;
#(
  parameter int MAX_FRACTION_DIGITS = DEFAULT_MAX_FRACTION_DIGITS,
  parameter int MAGNITUDE_BITS      = DEFAULT_MAGNITUDE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  dld_cmd_t    cmd,
  output dld_status_t status,
  input  logic [5:0]  fraction_digits,
  input  logic        numerator_negative,
  input  logic [31:0] numerator_magnitude,
  input  logic [3:0]  numerator_scale,
  input  logic        denominator_negative,
  input  logic [31:0] denominator_magnitude,
  input  logic [3:0]  denominator_scale,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  symbol_kind,
  output logic [3:0]  digit_value,
  output logic        last_symbol
);

  localparam int W   = MAGNITUDE_BITS + SCALE_BITS;
  localparam int TW  = W + 4;
  localparam int ND  = (W * 30103) / 100000 + 1;   // decimal digits of 2^W - 1
  localparam int DCW = $clog2(ND + 1);
  localparam int DVW = $clog2(W + 1);
  localparam int FW  = $clog2(MAX_FRACTION_DIGITS + 1);

  logic              show_minus;
  logic              den_zero;
  logic [3:0]        acnt;
  logic [3:0]        bcnt;
  logic [W-1:0]      a_reg;
  logic [W-1:0]      b_reg;
  logic [W-1:0]      rem;
  logic [4*ND-1:0]   bcd;
  logic [DVW-1:0]    divcnt;
  logic [DCW-1:0]    dcnt;
  logic [FW-1:0]     limit;
  logic [FW-1:0]     fcnt;
  logic [TW-1:0]     t_reg;
  logic [1:0]        fstep;
  logic [3:0]        fdig;

  logic [MAGNITUDE_BITS-1:0] nmag;
  logic [MAGNITUDE_BITS-1:0] dmag;
  logic [W:0]        rem_trial;
  logic [W:0]        rem_sub;
  logic              div_ge;
  logic [4*ND-1:0]   bcd_adj;
  logic [W-1:0]      a_times10;
  logic [W-1:0]      b_times10;
  logic [TW-1:0]     rem_times10;
  logic [TW-1:0]     b_shift;
  logic              t_ge;
  logic [3:0]        lead_digit;
  logic              point_last;
  logic              frac_last;
  logic [1:0]        emit_kind;
  logic [3:0]        emit_digit;
  logic              emit_last;

  assign nmag = numerator_magnitude[MAGNITUDE_BITS-1:0];
  assign dmag = denominator_magnitude[MAGNITUDE_BITS-1:0];

  // One restoring division step, quotient bit goes straight into the BCD shifter
  assign rem_trial = {rem, a_reg[W-1]};
  assign rem_sub   = rem_trial - {1'b0, b_reg};
  assign div_ge    = rem_trial >= {1'b0, b_reg};

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3
                                                  : bcd[4*i +: 4];
    end
  end

  assign a_times10   = (a_reg << 3) + (a_reg << 1);
  assign b_times10   = (b_reg << 3) + (b_reg << 1);
  assign rem_times10 = (TW'(rem) << 3) + (TW'(rem) << 1);
  assign b_shift     = TW'(b_reg) << fstep;
  assign t_ge        = t_reg >= b_shift;
  assign lead_digit  = bcd[4*ND-1 -: 4];

  assign point_last = (limit == '0) || (rem == '0);
  assign frac_last  = ((fcnt + FW'(1)) == limit) || (t_reg == '0);

  always_comb begin
    emit_kind  = KIND_DIGIT;
    emit_digit = 4'd0;
    emit_last  = 1'b0;
    unique case (cmd.emit_sel)
      EMIT_ERR: begin
        emit_kind = KIND_DIV_ZERO;
        emit_last = 1'b1;
      end
      EMIT_MINUS: emit_kind = KIND_MINUS;
      EMIT_INT:   emit_digit = lead_digit;
      EMIT_POINT: begin
        emit_kind = KIND_POINT;
        emit_last = point_last;
      end
      EMIT_FRAC: begin
        emit_digit = fdig;
        emit_last  = frac_last;
      end
      default: emit_kind = KIND_DIGIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg      <= W'(nmag);
      b_reg      <= W'(dmag);
      den_zero   <= (dmag == '0);
      show_minus <= (numerator_negative ^ denominator_negative) && (nmag != '0);
      acnt       <= clamp_scale(denominator_scale);
      bcnt       <= clamp_scale(numerator_scale);
      rem        <= '0;
      bcd        <= '0;
      divcnt     <= DVW'(W);
      dcnt       <= DCW'(ND);
      fcnt       <= '0;
      limit      <= (fraction_digits > 6'(MAX_FRACTION_DIGITS)) ?
                    FW'(MAX_FRACTION_DIGITS) : FW'(fraction_digits);
    end else if (cmd.scale) begin
      if (acnt != 4'd0) begin
        a_reg <= a_times10;
        acnt  <= acnt - 4'd1;
      end
      if (bcnt != 4'd0) begin
        b_reg <= b_times10;
        bcnt  <= bcnt - 4'd1;
      end
    end else if (cmd.div_step) begin
      a_reg  <= a_reg << 1;
      rem    <= div_ge ? rem_sub[W-1:0] : rem_trial[W-1:0];
      bcd    <= {bcd_adj[4*ND-2:0], div_ge};
      divcnt <= divcnt - DVW'(1);
    end else if (cmd.skip || (cmd.emit && cmd.emit_sel == EMIT_INT)) begin
      bcd  <= bcd << 4;
      dcnt <= dcnt - DCW'(1);
    end else if (cmd.frac_mul) begin
      t_reg <= rem_times10;
      fstep <= 2'd3;
      fdig  <= 4'd0;
    end else if (cmd.frac_step) begin
      if (t_ge) begin
        t_reg <= t_reg - b_shift;
      end
      fdig[fstep] <= t_ge;
      fstep       <= fstep - 2'd1;
    end else if (cmd.emit && cmd.emit_sel == EMIT_FRAC) begin
      rem  <= t_reg[W-1:0];
      fcnt <= fcnt + FW'(1);
    end
  end

  // Output register: free when empty or being taken this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      symbol_kind <= emit_kind;
      digit_value <= emit_digit;
      last_symbol <= emit_last;
    end
  end

  always_comb begin
    status.den_zero   = den_zero;
    status.scale_done = (acnt == 4'd0) && (bcnt == 4'd0);
    status.div_last   = (divcnt == DVW'(1));
    status.show_minus = show_minus;
    status.lead_zero  = (lead_digit == 4'd0);
    status.dcnt_one   = (dcnt == DCW'(1));
    status.frac_more  = !point_last;
    status.fstep_last = (fstep == 2'd0);
    status.frac_last  = frac_last;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== design/dld_controller.sv =====
module dld_controller
  import dld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  dld_status_t status,
  output dld_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_ERR   = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SIGN  = 4'd5;
  localparam logic [3:0] S_SKIP  = 4'd6;
  localparam logic [3:0] S_INT   = 4'd7;
  localparam logic [3:0] S_POINT = 4'd8;
  localparam logic [3:0] S_FMUL  = 4'd9;
  localparam logic [3:0] S_FSTEP = 4'd10;
  localparam logic [3:0] S_FEMIT = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = status.den_zero ? S_ERR : S_SCALE;
      S_ERR: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_ERR;
          state_next   = S_IDLE;
        end
      end
      S_SCALE: begin
        if (status.scale_done) begin
          state_next = S_DIV;
        end else begin
          cmd.scale = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        if (!status.show_minus) begin
          state_next = S_SKIP;
        end else if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_MINUS;
          state_next   = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keep at least one integer digit
        if (status.lead_zero && !status.dcnt_one) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = S_INT;
        end
      end
      S_INT: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_INT;
          if (status.dcnt_one) begin
            state_next = S_POINT;
          end
        end
      end
      S_POINT: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_POINT;
          state_next   = status.frac_more ? S_FMUL : S_IDLE;
        end
      end
      S_FMUL: begin
        cmd.frac_mul = 1'b1;
        state_next   = S_FSTEP;
      end
      S_FSTEP: begin
        cmd.frac_step = 1'b1;
        if (status.fstep_last) begin
          state_next = S_FEMIT;
        end
      end
      S_FEMIT: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_FRAC;
          state_next   = status.frac_last ? S_IDLE : S_FMUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/decimal_long_division.sv =====
// Decimal long divider. Takes one division request at a time and returns the
// quotient as a stream of symbols: an optional minus sign, the integer digits,
// a point and up to fraction_digits fraction digits (stopping once the
// remainder is zero); a zero denominator gives one divide-by-zero symbol.
// A request goes through these steps in order: the accept, the denominator
// check, scaling the operands by ten (each scale clamped to 9), the bit-serial
// integer division over W = MAGNITUDE_BITS + 30 bits (62 by default), the
// sign, dropping leading zeros, sending the integer digits (the zeros dropped
// and the digits sent always make up the 19 digits of the quotient register at
// default settings), the point, and a multiply by ten and a four-step digit
// loop per fraction digit. A zero denominator goes from the check straight to
// the divide-by-zero symbol. Every symbol waits for a free output register, so
// a stalled output stretches the request by the stall. The next request is
// taken as soon as the last symbol has been loaded into the output register.
`include "decimal_long_division_defines.svh"

module decimal_long_division
  import dld_pkg::*;
#(
  parameter int MAX_FRACTION_DIGITS = DEFAULT_MAX_FRACTION_DIGITS,
  parameter int MAGNITUDE_BITS      = DEFAULT_MAGNITUDE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  dld_in_if.sink                   in_ch,
  dld_out_if.source                out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [5:0]  fraction_digits;
  logic        in_ready;
  dld_cmd_t    cmd;
  dld_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_digits <= FRACTION_DIGITS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[APB_ADDR_BITS-1] == REG_FRACTION_DIGITS) begin
      fraction_digits <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[APB_ADDR_BITS-1] == REG_FRACTION_DIGITS) ?
                  {26'd0, fraction_digits} : 32'd0;

  assign in_ch.ready = in_ready;

  dld_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dld_datapath #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
    .MAGNITUDE_BITS      (MAGNITUDE_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .status                (status),
    .fraction_digits       (fraction_digits),
    .numerator_negative    (in_ch.numerator_negative),
    .numerator_magnitude   (in_ch.numerator_magnitude),
    .numerator_scale       (in_ch.numerator_scale),
    .denominator_negative  (in_ch.denominator_negative),
    .denominator_magnitude (in_ch.denominator_magnitude),
    .denominator_scale     (in_ch.denominator_scale),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .symbol_kind           (out_ch.symbol_kind),
    .digit_value           (out_ch.digit_value),
    .last_symbol           (out_ch.last_symbol)
  );

  `DLD_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "item taken while busy")
  `DLD_ASSERT_SAME(a_error_is_last, out_ch.valid && out_ch.symbol_kind == KIND_DIV_ZERO, out_ch.last_symbol, "divide-by-zero symbol not last")
  `DLD_ASSERT_SAME(a_digit_range, out_ch.valid && out_ch.symbol_kind == KIND_DIGIT, out_ch.digit_value <= 4'd9, "digit out of range")
  `DLD_ASSERT_SAME(a_mark_no_digit, out_ch.valid && out_ch.symbol_kind != KIND_DIGIT, out_ch.digit_value == 4'd0, "digit value on a non-digit symbol")

endmodule

// ===== bench/decimal_long_division_tb.sv =====
module decimal_long_division_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dld_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 400;
  localparam int RANDOM_ITEMS_PER_PHASE = 48;
  localparam int LONG_HOLD_CYCLES = 1500;

  localparam logic [APB_ADDR_BITS-1:0] ADDR_FRACTION_DIGITS =
    APB_ADDR_BITS'(4 * REG_FRACTION_DIGITS);
  // index 1 holds no register
  localparam logic [APB_ADDR_BITS-1:0] ADDR_UNMAPPED = APB_ADDR_BITS'(4);

  typedef struct packed {
    logic        nneg;
    logic [31:0] nmag;
    logic [3:0]  nsc;
    logic        dneg;
    logic [31:0] dmag;
    logic [3:0]  dsc;
  } division_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] digit;
    logic       last;
  } symbol_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dld_in_if  in_ch ();
  dld_out_if out_ch ();

  symbol_t expected_symbols[$];
  symbol_t oldest_symbol;
  logic [5:0] fraction_digits_cfg;
  int errors;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;

  decimal_long_division i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("decimal_long_division regression: fail");
    $finish;
  end

  function automatic logic [63:0] pow10(input logic [3:0] exponent);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < exponent; i++) p = p * 64'd10;
    return p;
  endfunction

  // Work out the symbol run of one quotient and queue it.
  function automatic void predict_quotient(input division_t d);
    logic [3:0]  nsc;
    logic [3:0]  dsc;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] q;
    logic [63:0] r;
    logic [67:0] tenfold;
    logic [3:0]  int_digits[$];
    symbol_t     run[$];
    int          limit;
    int          f;
    if (d.dmag == 32'd0) begin
      expected_symbols.push_back('{kind: KIND_DIV_ZERO, digit: 4'd0, last: 1'b1});
      return;
    end
    nsc = (d.nsc > MAX_SCALE) ? MAX_SCALE : d.nsc;
    dsc = (d.dsc > MAX_SCALE) ? MAX_SCALE : d.dsc;
    limit = (fraction_digits_cfg > DEFAULT_MAX_FRACTION_DIGITS) ?
            DEFAULT_MAX_FRACTION_DIGITS : int'(fraction_digits_cfg);
    a = 64'(d.nmag) * pow10(dsc);
    b = 64'(d.dmag) * pow10(nsc);
    q = a / b;
    r = a % b;
    if ((d.nneg != d.dneg) && d.nmag != 32'd0)
      run.push_back('{kind: KIND_MINUS, digit: 4'd0, last: 1'b0});
    do begin
      int_digits.push_front(4'(q % 64'd10));
      q = q / 64'd10;
    end while (q != 64'd0);
    foreach (int_digits[i])
      run.push_back('{kind: KIND_DIGIT, digit: int_digits[i], last: 1'b0});
    run.push_back('{kind: KIND_POINT, digit: 4'd0, last: 1'b0});
    f = 0;
    while (f < limit && r != 64'd0) begin
      tenfold = 68'(r) * 68'd10;
      run.push_back('{kind: KIND_DIGIT, digit: 4'(tenfold / 68'(b)), last: 1'b0});
      r = 64'(tenfold % 68'(b));
      f++;
    end
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_symbols.push_back(run[i]);
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Compare each symbol taken from the block with the oldest expectation.
  always @(negedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_symbols.size() == 0) begin
        errors++;
        $display("%0t: symbol expected none, actual kind %0d digit %0d last %0d",
                 $time, out_ch.symbol_kind, out_ch.digit_value, out_ch.last_symbol);
      end else begin
        oldest_symbol = expected_symbols.pop_front();
        check_field("symbol_kind", oldest_symbol.kind, out_ch.symbol_kind);
        check_field("digit_value", oldest_symbol.digit, out_ch.digit_value);
        check_field("last_symbol", oldest_symbol.last, out_ch.last_symbol);
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one division request and hold it until taken.
  task automatic send_division(input division_t d);
    logic accepted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid                 <= 1'b1;
    in_ch.numerator_negative    <= d.nneg;
    in_ch.numerator_magnitude   <= d.nmag;
    in_ch.numerator_scale       <= d.nsc;
    in_ch.denominator_negative  <= d.dneg;
    in_ch.denominator_magnitude <= d.dmag;
    in_ch.denominator_scale     <= d.dsc;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      if (in_ch.ready) begin
        accepted = 1'b1;
        predict_quotient(d);
      end
      @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [APB_ADDR_BITS-1:0] addr,
                                input logic [31:0] value);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_FRACTION_DIGITS) fraction_digits_cfg = value[5:0];
  endtask

  task automatic wait_for_quotients();
    in_ch.valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
  endtask

  function automatic division_t make_division(input logic nneg, input logic [31:0] nmag,
                                              input logic [3:0] nsc, input logic dneg,
                                              input logic [31:0] dmag,
                                              input logic [3:0] dsc);
    return '{nneg: nneg, nmag: nmag, nsc: nsc, dneg: dneg, dmag: dmag, dsc: dsc};
  endfunction

  function automatic division_t random_division();
    division_t d;
    d.nneg = 1'($urandom_range(1));
    d.dneg = 1'($urandom_range(1));
    d.nsc  = 4'($urandom_range(15));
    d.dsc  = 4'($urandom_range(15));
    case ($urandom_range(9))
      0:       d.nmag = 32'd0;
      1, 2:    d.nmag = $urandom_range(999);
      3:       d.nmag = $urandom_range(99999);
      default: d.nmag = $urandom;
    endcase
    case ($urandom_range(19))
      0:          d.dmag = 32'd0;
      1, 2, 3:    d.dmag = $urandom_range(1, 99);
      4, 5:       d.dmag = $urandom_range(1, 99999);
      default:    d.dmag = $urandom;
    endcase
    return d;
  endfunction

  task automatic test_reset_setting();
    // reset leaves six fraction digits
    send_division(make_division(1'b0, 32'd1, 4'd0, 1'b0, 32'd3, 4'd0));
    send_division(make_division(1'b0, 32'd2, 4'd0, 1'b1, 32'd7, 4'd0));
    wait_for_quotients();
  endtask

  task automatic test_directed();
    send_division(make_division(1'b1, 32'd0, 4'd3, 1'b0, 32'd5, 4'd0));
    send_division(make_division(1'b0, 32'd5, 4'd0, 1'b0, 32'd0, 4'd0));
    send_division(make_division(1'b1, 32'd5, 4'd2, 1'b1, 32'd0, 4'd4));
    send_division(make_division(1'b0, 32'd0, 4'd0, 1'b1, 32'd0, 4'd0));
    send_division(make_division(1'b0, 32'd7, 4'd0, 1'b1, 32'd1, 4'd0));
    send_division(make_division(1'b1, 32'hFFFF_FFFF, 4'd0, 1'b1, 32'hFFFF_FFFF, 4'd0));
    send_division(make_division(1'b0, 32'hFFFF_FFFF, 4'd0, 1'b0, 32'd1, 4'd9));
    send_division(make_division(1'b1, 32'd1, 4'd9, 1'b0, 32'hFFFF_FFFF, 4'd0));
    send_division(make_division(1'b0, 32'd12345, 4'd15, 1'b0, 32'd7, 4'd12));
    send_division(make_division(1'b0, 32'd10, 4'd1, 1'b1, 32'd1, 4'd0));
    send_division(make_division(1'b0, 32'd1, 4'd0, 1'b0, 32'd8, 4'd0));
    send_division(make_division(1'b1, 32'd22, 4'd0, 1'b1, 32'd7, 4'd0));
    wait_for_quotients();
    write_register(ADDR_FRACTION_DIGITS, 32'd32);
    send_division(make_division(1'b0, 32'd1, 4'd0, 1'b0, 32'd7, 4'd0));
    send_division(make_division(1'b1, 32'd1, 4'd9, 1'b0, 32'hFFFF_FFFF, 4'd0));
    send_division(make_division(1'b0, 32'hFFFF_FFFF, 4'd0, 1'b1, 32'd3, 4'd9));
    wait_for_quotients();
    // above the ceiling, so the block caps it
    write_register(ADDR_FRACTION_DIGITS, 32'hFFFF_FFFF);
    send_division(make_division(1'b0, 32'd1, 4'd0, 1'b0, 32'd3, 4'd0));
    wait_for_quotients();
    write_register(ADDR_FRACTION_DIGITS, 32'd40);
    send_division(make_division(1'b0, 32'd2, 4'd0, 1'b1, 32'd3, 4'd0));
    wait_for_quotients();
    write_register(ADDR_FRACTION_DIGITS, 32'd0);
    send_division(make_division(1'b1, 32'd1, 4'd0, 1'b0, 32'd3, 4'd0));
    send_division(make_division(1'b0, 32'd9, 4'd0, 1'b0, 32'd3, 4'd0));
    wait_for_quotients();
    // nothing lives at this address; the setting must hold
    write_register(ADDR_UNMAPPED, 32'd17);
    send_division(make_division(1'b0, 32'd1, 4'd0, 1'b0, 32'd3, 4'd0));
    wait_for_quotients();
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic [31:0] digits);
    write_register(ADDR_FRACTION_DIGITS, digits);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (RANDOM_ITEMS_PER_PHASE) send_division(random_division());
    wait_for_quotients();
  endtask

  task automatic test_output_hold_off();
    write_register(ADDR_FRACTION_DIGITS, 32'd20);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = LONG_HOLD_CYCLES;
    repeat (8) send_division(random_division());
    wait_for_quotients();
  endtask

  initial begin
    rst                         = 1'b1;
    in_ch.valid                 = 1'b0;
    in_ch.numerator_negative    = 1'b0;
    in_ch.numerator_magnitude   = '0;
    in_ch.numerator_scale       = '0;
    in_ch.denominator_negative  = 1'b0;
    in_ch.denominator_magnitude = '0;
    in_ch.denominator_scale     = '0;
    psel                        = 1'b0;
    penable                     = 1'b0;
    pwrite                      = 1'b0;
    paddr                       = '0;
    pwdata                      = '0;
    fraction_digits_cfg         = FRACTION_DIGITS_RESET;
    errors                      = 0;
    send_idle_pct               = 0;
    recv_stall_pct              = 0;
    hold_off_left               = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_setting();
    test_directed();
    test_random_phase(0, 0, $urandom_range(63));
    test_random_phase(45, 0, $urandom_range(12));
    test_random_phase(0, 45, $urandom_range(63));
    test_random_phase(22, 22, $urandom_range(40));
    test_output_hold_off();

    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_symbols.size() != 0) begin
      errors++;
      $display("%0t: %0d symbols expected, none arrived", $time, expected_symbols.size());
    end
    if (errors == 0) begin
      $display("decimal_long_division regression: pass");
    end else begin
      $display("decimal_long_division regression: fail");
    end
    $finish;
  end

endmodule
